>>> rtl/vwgr_pkg.sv
// Shared types, opcodes, register indexes and arithmetic helpers of the water grid relaxer.
package vwgr_pkg;

    typedef struct packed {
        logic signed [31:0] height;
        logic signed [31:0] velocity;
        logic [7:0]         pref;
        logic               moving;
    } t_vertex;

    typedef struct packed {
        logic vld;
        logic tick;
    } t_rmw_ctl;

    typedef enum logic [1:0] {
        OP_SPLASH = 2'd0,
        OP_TICK   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_READ   = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        CFG_ORIGIN_X  = 3'd0,
        CFG_ORIGIN_Y  = 3'd1,
        CFG_COS       = 3'd2,
        CFG_SIN       = 3'd3,
        CFG_INV_CELL  = 3'd4,
        CFG_RANGE     = 3'd5,
        CFG_CELLS_X   = 3'd6,
        CFG_CELLS_Y   = 3'd7
    } t_cfg_index;

    localparam logic signed [16:0] DAMPING_Q         = 17'sd62915;
    localparam logic signed [33:0] HEIGHT_SETTLE_Q   = 34'sd6554;
    localparam logic signed [31:0] VELOCITY_SETTLE_Q = 32'sd3277;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -35'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/vwgr_store.sv
// Vertex store: one synchronous memory, one write and one registered read port.
module vwgr_store
    import vwgr_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_vertex       i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_vertex       o_rdata
);

    t_vertex r_mem [DEPTH];
    t_vertex r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/vwgr_map.sv
// Splash mapping pipeline: world point to rotated, scaled grid coordinates in Q30.16.
module vwgr_map (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_world_x,
    input  logic signed [31:0] i_world_y,
    input  logic signed [31:0] i_origin_x,
    input  logic signed [31:0] i_origin_y,
    input  logic signed [17:0] i_cos,
    input  logic signed [17:0] i_sin,
    input  logic [24:0]        i_inv,
    output logic               o_done,
    output logic signed [45:0] o_gx,
    output logic signed [45:0] o_gy
);

    logic [4:0]         r_vld;
    logic signed [32:0] r_dx, r_dy;
    logic signed [50:0] r_p1, r_p2, r_p3, r_p4;
    logic signed [35:0] r_tx, r_ty;
    logic [42:0]        r_lox, r_loy;
    logic signed [43:0] r_hix, r_hiy;
    logic signed [45:0] r_gx, r_gy;
    logic signed [51:0] w_sx, w_sy;
    logic [61:0]        w_px, w_py;

    assign w_sx = 52'(r_p1) + 52'(r_p2);
    assign w_sy = 52'(r_p3) - 52'(r_p4);
    assign w_px = {r_hix, 18'b0} + 62'(r_lox);
    assign w_py = {r_hiy, 18'b0} + 62'(r_loy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx  <= 33'(i_world_x) - 33'(i_origin_x);
        r_dy  <= 33'(i_world_y) - 33'(i_origin_y);
        r_p1  <= r_dx * i_cos;
        r_p2  <= r_dy * i_sin;
        r_p3  <= r_dy * i_cos;
        r_p4  <= r_dx * i_sin;
        r_tx  <= w_sx[51:16];
        r_ty  <= w_sy[51:16];
        r_lox <= r_tx[17:0] * i_inv;
        r_loy <= r_ty[17:0] * i_inv;
        r_hix <= $signed(r_tx[35:18]) * $signed({1'b0, i_inv});
        r_hiy <= $signed(r_ty[35:18]) * $signed({1'b0, i_inv});
        r_gx  <= w_px[61:16];
        r_gy  <= w_py[61:16];
    end

    assign o_done = r_vld[4];
    assign o_gx   = r_gx;
    assign o_gy   = r_gy;

endmodule

>>> rtl/vwgr_relax.sv
// Read-modify-write pipeline: splash velocity add and tick damping, gravity and settle.
module vwgr_relax
    import vwgr_pkg::*;
#(
    parameter int AW = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_rmw_ctl           i_ctl,
    input  logic [AW-1:0]      i_addr,
    input  t_vertex            i_rdata,
    input  logic signed [31:0] i_svel,
    input  logic signed [31:0] i_gstep,
    input  logic [7:0]         i_spref,
    output logic               o_we,
    output logic [AW-1:0]      o_waddr,
    output t_vertex            o_wdata,
    output logic               o_unsettled,
    output logic               o_busy
);

    t_rmw_ctl           r1_ctl, r2_ctl, r3_ctl;
    logic [AW-1:0]      r1_addr, r2_addr, r3_addr;
    t_vertex            r2_d, r3_d;
    logic signed [48:0] r2_prod;
    logic signed [31:0] r3_v;

    logic signed [48:0] w_rnd;
    logic signed [32:0] w_vd;
    logic signed [33:0] w_p2, w_p3, w_dh;
    logic signed [34:0] w_vt, w_h35;
    logic signed [31:0] w_v2, w_h2;
    logic               w_settle;

    assign w_rnd = r2_prod + 49'sd32768;
    assign w_vd  = w_rnd[48:16];
    assign w_p2  = $signed({10'b0, r2_d.pref, 16'b0});
    assign w_vt  = (34'(r2_d.height) < w_p2) ? 35'(w_vd) - 35'(i_gstep)
                                             : 35'(w_vd) + 35'(i_gstep);
    assign w_v2  = r2_ctl.tick ? sat32(w_vt) : sat32(35'(r2_d.velocity) + 35'(i_svel));

    assign w_p3     = $signed({10'b0, r3_d.pref, 16'b0});
    assign w_h35    = 35'(r3_d.height) + 35'(r3_v);
    assign w_h2     = sat32(w_h35);
    assign w_dh     = 34'(w_h2) - w_p3;
    assign w_settle = (w_dh > -HEIGHT_SETTLE_Q) && (w_dh < HEIGHT_SETTLE_Q) &&
                      (r3_v > -VELOCITY_SETTLE_Q) && (r3_v < VELOCITY_SETTLE_Q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
            r2_ctl <= '0;
            r3_ctl <= '0;
        end else begin
            r1_ctl <= i_ctl;
            r2_ctl <= r1_ctl;
            r3_ctl <= r2_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_addr <= i_addr;
        r2_addr <= r1_addr;
        r3_addr <= r2_addr;
        r2_d    <= i_rdata;
        r2_prod <= i_rdata.velocity * DAMPING_Q;
        r3_d    <= r2_d;
        r3_v    <= w_v2;
    end

    always_comb begin
        o_wdata = r3_d;
        if (!r3_ctl.tick) begin
            o_wdata.velocity = r3_v;
            o_wdata.pref     = i_spref;
            o_wdata.moving   = 1'b1;
        end else if (w_settle) begin
            o_wdata.height   = w_p3[31:0];
            o_wdata.velocity = '0;
            o_wdata.moving   = 1'b0;
        end else begin
            o_wdata.height   = w_h2;
            o_wdata.velocity = r3_v;
        end
    end

    assign o_we        = r3_ctl.vld && (!r3_ctl.tick || r3_d.moving);
    assign o_waddr     = r3_addr;
    assign o_unsettled = r3_ctl.vld && r3_ctl.tick && r3_d.moving && !w_settle;
    assign o_busy      = r1_ctl.vld || r2_ctl.vld || r3_ctl.vld;

endmodule

>>> rtl/vertex_water_grid_relaxer.sv
// Top level of the water grid relaxer: registers, sequencer and vertex store.
// One item is worked at a time and gives one result item. The vertex store is a
// single memory of (min(MAX_CELLS,63)+1)^2 entries that the sequencer walks one
// entry a cycle through a read-modify-write pipeline. A tick walks all
// (cells_x+1)*(cells_y+1) vertices of the grid, or none when nothing moves; a
// splash walks each vertex of its square; a clear sweeps the whole store. After
// reset the block sweeps the store to zero and holds o_stall meanwhile;
// configuration writes are taken at any time. A finished result waits in the
// output register while the next item is accepted.
module vertex_water_grid_relaxer
    import vwgr_pkg::*;
#(
    parameter int MAX_CELLS = 63
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_opcode,
    input  logic signed [31:0] i_world_x,
    input  logic signed [31:0] i_world_y,
    input  logic signed [31:0] i_splash_velocity,
    input  logic [7:0]         i_preferred_level,
    input  logic signed [31:0] i_gravity,
    input  logic [5:0]         i_read_x,
    input  logic [5:0]         i_read_y,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_accepted,
    output logic signed [31:0] o_vertex_height,
    output logic signed [31:0] o_vertex_velocity,
    output logic [7:0]         o_vertex_preferred,
    output logic               o_vertex_moving,
    output logic               o_any_moving,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam int CLAMP = (MAX_CELLS < 63) ? MAX_CELLS : 63;
    localparam int AXIS  = CLAMP + 1;
    localparam int DEPTH = AXIS * AXIS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [5:0] CELL_CAP = 6'(CLAMP);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_CLEAR  = 11'b00000000010,
        S_MAP    = 11'b00000000100,
        S_BOUND  = 11'b00000001000,
        S_ROWB   = 11'b00000010000,
        S_SPLASH = 11'b00000100000,
        S_TICK   = 11'b00001000000,
        S_READ   = 11'b00010000000,
        S_RDWAIT = 11'b00100000000,
        S_DRAIN  = 11'b01000000000,
        S_RESP   = 11'b10000000000
    } t_state;

    t_state             r_state;
    logic signed [31:0] r_origin_x, r_origin_y;
    logic signed [17:0] r_cos, r_sin;
    logic [24:0]        r_inv;
    logic [22:0]        r_range;
    logic [5:0]         r_cells_x, r_cells_y;

    logic [AW:0]        r_cnt, r_n;
    logic [AW-1:0]      r_row;
    logic [5:0]         r_x, r_y, r_x0, r_x1, r_y1, r_rx, r_ry;
    logic signed [45:0] r_gx, r_gy;
    logic               r_gmov, r_clr_op;
    logic signed [31:0] r_svel, r_gstep;
    logic [7:0]         r_spref;

    logic               r_res_acc;
    t_vertex            r_res;
    logic               r_out_valid, r_out_acc, r_out_any;
    t_vertex            r_out;

    logic [5:0]         w_cx, w_cy;
    logic [6:0]         w_stride;
    logic [AW-1:0]      w_rd_addr, w_raddr;
    logic               w_in_acc, w_map_done, w_reject;
    logic signed [45:0] w_map_gx, w_map_gy;
    logic signed [46:0] w_rng;
    logic signed [32:0] w_g1;
    t_rmw_ctl           w_ctl;
    t_vertex            w_rdata, w_rlx_wdata, w_wdata;
    logic               w_rlx_we, w_we, w_unsettled, w_busy;
    logic [AW-1:0]      w_rlx_waddr, w_waddr;

    function automatic logic [5:0] bound_lo(input logic signed [46:0] v,
                                           input logic [5:0] cells);
        logic [5:0] r;
        if (v <= 47'sd0) begin
            r = '0;
        end else if (v >= $signed(47'({cells, 16'b0}))) begin
            r = cells;
        end else begin
            r = v[21:16];
        end
        return r;
    endfunction

    function automatic logic [5:0] bound_hi(input logic signed [46:0] v,
                                           input logic [5:0] cells);
        logic [5:0]         r;
        logic signed [46:0] vv;
        vv = v + 47'sd65535;
        if (v <= 47'sd0) begin
            r = '0;
        end else if (v >= $signed(47'({cells, 16'b0}))) begin
            r = cells;
        end else begin
            r = vv[21:16];
        end
        return r;
    endfunction

    assign w_cx = (r_cells_x == 6'd0) ? 6'd1 : ((r_cells_x > CELL_CAP) ? CELL_CAP : r_cells_x);
    assign w_cy = (r_cells_y == 6'd0) ? 6'd1 : ((r_cells_y > CELL_CAP) ? CELL_CAP : r_cells_y);
    assign w_stride  = {1'b0, w_cx} + 7'd1;
    assign w_rd_addr = AW'(AW'(r_ry) * AW'(w_stride)) + AW'(r_rx);
    assign w_rng     = $signed(47'(r_range));
    assign w_g1      = 33'(i_gravity) + 33'sd1;
    assign w_reject  = (r_gx < 46'sd0) || (r_gy < 46'sd0) ||
                       (r_gx > $signed(46'({w_cx - 6'd1, 16'b0}))) ||
                       (r_gy > $signed(46'({w_cy - 6'd1, 16'b0})));

    assign o_stall  = (r_state != S_IDLE) || !i_rst_n;
    assign w_in_acc = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    assign w_ctl.vld  = (r_state == S_SPLASH) || (r_state == S_TICK);
    assign w_ctl.tick = (r_state == S_TICK);

    always_comb begin
        case (r_state)
            S_SPLASH: w_raddr = r_row + AW'(r_x);
            S_TICK:   w_raddr = r_cnt[AW-1:0];
            default:  w_raddr = w_rd_addr;
        endcase
    end

    assign w_we    = (r_state == S_CLEAR) ? 1'b1 : w_rlx_we;
    assign w_waddr = (r_state == S_CLEAR) ? r_cnt[AW-1:0] : w_rlx_waddr;
    assign w_wdata = (r_state == S_CLEAR) ? '0 : w_rlx_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_cos      <= 18'sd65536;
            r_sin      <= '0;
            r_inv      <= 25'd65536;
            r_range    <= '0;
            r_cells_x  <= 6'd63;
            r_cells_y  <= 6'd63;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_ORIGIN_X: r_origin_x <= i_cfg_data;
                CFG_ORIGIN_Y: r_origin_y <= i_cfg_data;
                CFG_COS:      r_cos      <= i_cfg_data[17:0];
                CFG_SIN:      r_sin      <= i_cfg_data[17:0];
                CFG_INV_CELL: r_inv      <= i_cfg_data[24:0];
                CFG_RANGE:    r_range    <= i_cfg_data[22:0];
                CFG_CELLS_X:  r_cells_x  <= i_cfg_data[5:0];
                CFG_CELLS_Y:  r_cells_y  <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_gmov      <= 1'b0;
            r_clr_op    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_unsettled) begin
                r_gmov <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_res_acc <= 1'b1;
                        r_res     <= '0;
                        case (t_opcode'(i_opcode))
                            OP_SPLASH: begin
                                r_svel  <= i_splash_velocity;
                                r_spref <= i_preferred_level;
                                r_state <= S_MAP;
                            end
                            OP_TICK: begin
                                r_cnt   <= '0;
                                r_n     <= (AW+1)'((AW+1)'(w_stride) *
                                                   (AW+1)'({1'b0, w_cy} + 7'd1));
                                r_gstep <= w_g1[32:1];
                                if (r_gmov) begin
                                    r_gmov  <= 1'b0;
                                    r_state <= S_TICK;
                                end else begin
                                    r_state <= S_RESP;
                                end
                            end
                            OP_CLEAR: begin
                                r_cnt    <= '0;
                                r_clr_op <= 1'b1;
                                r_state  <= S_CLEAR;
                            end
                            OP_READ: begin
                                r_rx    <= i_read_x;
                                r_ry    <= i_read_y;
                                r_state <= S_READ;
                            end
                            default: r_state <= S_RESP;
                        endcase
                    end
                end
                S_CLEAR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == (AW+1)'(DEPTH - 1)) begin
                        r_gmov   <= 1'b0;
                        r_clr_op <= 1'b0;
                        r_state  <= r_clr_op ? S_RESP : S_IDLE;
                    end
                end
                S_MAP: begin
                    if (w_map_done) begin
                        r_gx    <= w_map_gx;
                        r_gy    <= w_map_gy;
                        r_state <= S_BOUND;
                    end
                end
                S_BOUND: begin
                    if (w_reject) begin
                        r_res_acc <= 1'b0;
                        r_state   <= S_RESP;
                    end else begin
                        r_x0    <= bound_lo(47'(r_gx) - w_rng, w_cx);
                        r_x     <= bound_lo(47'(r_gx) - w_rng, w_cx);
                        r_x1    <= bound_hi(47'(r_gx) + w_rng, w_cx);
                        r_y     <= bound_lo(47'(r_gy) - w_rng, w_cy);
                        r_y1    <= bound_hi(47'(r_gy) + w_rng, w_cy);
                        r_state <= S_ROWB;
                    end
                end
                S_ROWB: begin
                    r_row   <= AW'(AW'(r_y) * AW'(w_stride));
                    r_state <= S_SPLASH;
                end
                S_SPLASH: begin
                    if (r_x == r_x1) begin
                        if (r_y == r_y1) begin
                            r_gmov  <= 1'b1;
                            r_state <= S_DRAIN;
                        end else begin
                            r_y   <= r_y + 6'd1;
                            r_x   <= r_x0;
                            r_row <= r_row + AW'(w_stride);
                        end
                    end else begin
                        r_x <= r_x + 6'd1;
                    end
                end
                S_TICK: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == r_n - 1'b1) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_READ: begin
                    if (r_rx > w_cx || r_ry > w_cy) begin
                        r_res_acc <= 1'b0;
                        r_state   <= S_RESP;
                    end else begin
                        r_state <= S_RDWAIT;
                    end
                end
                S_RDWAIT: begin
                    r_res   <= w_rdata;
                    r_state <= S_RESP;
                end
                S_DRAIN: begin
                    if (!w_busy) begin
                        r_state <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_acc   <= r_res_acc;
                        r_out       <= r_res;
                        r_out_any   <= r_gmov;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid            = r_out_valid;
    assign o_accepted         = r_out_acc;
    assign o_vertex_height    = r_out.height;
    assign o_vertex_velocity  = r_out.velocity;
    assign o_vertex_preferred = r_out.pref;
    assign o_vertex_moving    = r_out.moving;
    assign o_any_moving       = r_out_any;

    vwgr_map u_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_in_acc && (t_opcode'(i_opcode) == OP_SPLASH)),
        .i_world_x  (i_world_x),
        .i_world_y  (i_world_y),
        .i_origin_x (r_origin_x),
        .i_origin_y (r_origin_y),
        .i_cos      (r_cos),
        .i_sin      (r_sin),
        .i_inv      (r_inv),
        .o_done     (w_map_done),
        .o_gx       (w_map_gx),
        .o_gy       (w_map_gy)
    );

    vwgr_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    vwgr_relax #(.AW(AW)) u_relax (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_addr      (w_raddr),
        .i_rdata     (w_rdata),
        .i_svel      (r_svel),
        .i_gstep     (r_gstep),
        .i_spref     (r_spref),
        .o_we        (w_rlx_we),
        .o_waddr     (w_rlx_waddr),
        .o_wdata     (w_rlx_wdata),
        .o_unsettled (w_unsettled),
        .o_busy      (w_busy)
    );

endmodule

>>> rtl/vwgr_checker.sv
// Port-level checks of the water grid relaxer and their binding to the top level.
module vwgr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_accepted,
    input logic [31:0] o_vertex_height,
    input logic [31:0] o_vertex_velocity,
    input logic [7:0]  o_vertex_preferred,
    input logic        o_vertex_moving,
    input logic        o_any_moving
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_vertex_height) && $stable(o_accepted))
        else $error("result item changed while stalled");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second item taken before the first finished");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_accepted |-> o_vertex_height == 32'd0 && o_vertex_velocity == 32'd0 &&
            o_vertex_preferred == 8'd0 && !o_vertex_moving)
        else $error("rejected item carries vertex data");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result item after reset");

endmodule

bind vertex_water_grid_relaxer vwgr_checker u_vwgr_checker (.*);
